### design/aabb_affine_transform_defines.svh
// Assertion macros for the transformed bounding box block.
// Used by the top level; depends on nothing else.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aat_pkg.sv
// Shared types and constants for the transformed bounding box block.
// Used by aat_regs, aat_axis and aabb_affine_transform; depends on nothing.
`default_nettype none

package aat_pkg;

  localparam int CW        = 24;
  localparam int KW        = 18;
  localparam int FRAC      = KW - 2;
  localparam int ROW_W     = 3 * KW;
  localparam int P_W       = CW + KW;
  localparam int A_W       = P_W + 2;
  localparam int R_W       = A_W - FRAC;
  localparam int NS        = 5;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_LSB   = 3;
  localparam int IDX_W     = ADDR_W - IDX_LSB;

  localparam logic [IDX_W-1:0] REG_LIN_ROW_X = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LIN_ROW_Y = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LIN_ROW_Z = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_OFFSET_X  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_OFFSET_Y  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_OFFSET_Z  = IDX_W'(5);

  localparam logic [KW-1:0] COEF_ONE = KW'(1) << FRAC;

  typedef struct packed {
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] lo_z;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] hi_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_lo_x;
    logic signed [CW-1:0] out_lo_y;
    logic signed [CW-1:0] out_lo_z;
    logic signed [CW-1:0] out_hi_x;
    logic signed [CW-1:0] out_hi_y;
    logic signed [CW-1:0] out_hi_z;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] row;
    logic [2:0][CW-1:0]    offset;
  } cfg_t;

  typedef struct packed {
    logic [NS-1:0] adv;
  } pipe_ctl_t;

endpackage

`default_nettype wire

### design/aat_regs.sv
// Configuration register file behind the APB-style port.
// Depends on aat_pkg.
`default_nettype none

module aat_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [aat_pkg::ADDR_W-1:0] paddr,
  input  wire logic [aat_pkg::DATA_W-1:0] pwdata,
  output logic      [aat_pkg::DATA_W-1:0] prdata,
  output aat_pkg::cfg_t                   cfg
);
  import aat_pkg::*;

  logic [2:0][ROW_W-1:0] row_r;
  logic [2:0][CW-1:0]    offset_r;
  logic [IDX_W-1:0]      idx;
  logic                  wr;

  assign idx = paddr[ADDR_W-1:IDX_LSB];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]    <= ROW_W'(COEF_ONE);
      row_r[1]    <= ROW_W'(COEF_ONE) << KW;
      row_r[2]    <= ROW_W'(COEF_ONE) << (2 * KW);
      offset_r[0] <= '0;
      offset_r[1] <= '0;
      offset_r[2] <= '0;
    end else if (wr) begin
      case (idx)
        REG_LIN_ROW_X: row_r[0]    <= pwdata[ROW_W-1:0];
        REG_LIN_ROW_Y: row_r[1]    <= pwdata[ROW_W-1:0];
        REG_LIN_ROW_Z: row_r[2]    <= pwdata[ROW_W-1:0];
        REG_OFFSET_X:  offset_r[0] <= pwdata[CW-1:0];
        REG_OFFSET_Y:  offset_r[1] <= pwdata[CW-1:0];
        REG_OFFSET_Z:  offset_r[2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIN_ROW_X: prdata = DATA_W'(row_r[0]);
      REG_LIN_ROW_Y: prdata = DATA_W'(row_r[1]);
      REG_LIN_ROW_Z: prdata = DATA_W'(row_r[2]);
      REG_OFFSET_X:  prdata = DATA_W'(offset_r[0]);
      REG_OFFSET_Y:  prdata = DATA_W'(offset_r[1]);
      REG_OFFSET_Z:  prdata = DATA_W'(offset_r[2]);
      default:       prdata = '0;
    endcase
  end

  assign cfg.row    = row_r;
  assign cfg.offset = offset_r;

endmodule

`default_nettype wire

### design/aat_axis.sv
// Five-stage datapath for one output axis: products, per-term min and max,
// two adder levels with rounding, then clamping. Depends on aat_pkg.
`default_nettype none

module aat_axis (
  input  wire logic                  clk,
  input  wire aat_pkg::pipe_ctl_t    ctl,
  input  wire logic [aat_pkg::ROW_W-1:0] row,
  input  wire logic [aat_pkg::CW-1:0]    offset,
  input  wire aat_pkg::in_item_t     item,
  output logic signed [aat_pkg::CW-1:0]  lo_o,
  output logic signed [aat_pkg::CW-1:0]  hi_o,
  output logic                       sat_o
);
  import aat_pkg::*;

  localparam logic signed [R_W-1:0] CMAX = {{(R_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [R_W-1:0] CMIN = ~CMAX;

  logic signed [CW-1:0]  lo_in [3];
  logic signed [CW-1:0]  hi_in [3];
  logic signed [KW-1:0]  coef  [3];
  logic signed [P_W-1:0] plo_r [3];
  logic signed [P_W-1:0] phi_r [3];
  logic signed [P_W-1:0] tmin_r [3];
  logic signed [P_W-1:0] tmax_r [3];
  logic signed [A_W-1:0] offc;
  logic signed [A_W-1:0] mn_a_r, mn_b_r, mx_a_r, mx_b_r;
  logic signed [A_W-1:0] mn_sum, mx_sum;
  logic signed [R_W-1:0] rmin_r, rmax_r;
  logic signed [CW-1:0]  lo_r, hi_r;
  logic                  sat_r;

  assign lo_in[0] = item.lo_x;
  assign lo_in[1] = item.lo_y;
  assign lo_in[2] = item.lo_z;
  assign hi_in[0] = item.hi_x;
  assign hi_in[1] = item.hi_y;
  assign hi_in[2] = item.hi_z;

  // The offset enters already scaled, with the rounding half folded in.
  assign offc = {(R_W)'($signed(offset)), 1'b1, {(FRAC-1){1'b0}}};

  for (genvar k = 0; k < 3; k++) begin : g_term
    assign coef[k] = row[k*KW +: KW];

    always_ff @(posedge clk) begin
      if (ctl.adv[0]) begin
        plo_r[k] <= P_W'(coef[k]) * P_W'(lo_in[k]);
        phi_r[k] <= P_W'(coef[k]) * P_W'(hi_in[k]);
      end
      if (ctl.adv[1]) begin
        tmin_r[k] <= (plo_r[k] < phi_r[k]) ? plo_r[k] : phi_r[k];
        tmax_r[k] <= (plo_r[k] < phi_r[k]) ? phi_r[k] : plo_r[k];
      end
    end
  end

  assign mn_sum = mn_a_r + mn_b_r;
  assign mx_sum = mx_a_r + mx_b_r;

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      mn_a_r <= A_W'(tmin_r[0]) + A_W'(tmin_r[1]);
      mn_b_r <= A_W'(tmin_r[2]) + offc;
      mx_a_r <= A_W'(tmax_r[0]) + A_W'(tmax_r[1]);
      mx_b_r <= A_W'(tmax_r[2]) + offc;
    end
    if (ctl.adv[3]) begin
      rmin_r <= mn_sum[A_W-1:FRAC];
      rmax_r <= mx_sum[A_W-1:FRAC];
    end
    if (ctl.adv[4]) begin
      lo_r  <= (rmin_r > CMAX) ? CMAX[CW-1:0] :
               (rmin_r < CMIN) ? CMIN[CW-1:0] : rmin_r[CW-1:0];
      hi_r  <= (rmax_r > CMAX) ? CMAX[CW-1:0] :
               (rmax_r < CMIN) ? CMIN[CW-1:0] : rmax_r[CW-1:0];
      sat_r <= (rmin_r > CMAX) || (rmin_r < CMIN) ||
               (rmax_r > CMAX) || (rmax_r < CMIN);
    end
  end

  assign lo_o  = lo_r;
  assign hi_o  = hi_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire

### design/aabb_affine_transform.sv
// Top level of the transformed bounding box block: register file, pipeline
// control and three axis datapaths. Depends on aat_pkg, aat_regs, aat_axis.
//
//   channel | direction | handshake                  | payload
//   in_     | input     | in_valid / in_stall        | in_data (in_item_t)
//   out_    | output    | out_valid / out_stall      | out_data (out_item_t)
//   cfg_    | input     | cfg_psel / cfg_penable     | cfg_paddr, cfg_pwdata
//
// One item is accepted per cycle while in_stall is low; each result passes
// through the multiply, min/max, two adder and clamp stages in that order.
// Reset is synchronous; it clears the valid bits and loads the identity rows and zero offsets.
// A stall holds only the stages that are full; empty stages keep filling.
`default_nettype none

`include "aabb_affine_transform_defines.svh"

module aabb_affine_transform (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire aat_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output aat_pkg::out_item_t              out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [aat_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [aat_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [aat_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import aat_pkg::*;

  cfg_t          cfg;
  pipe_ctl_t     ctl;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [2:0]    sat;
  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];

  assign cfg_pready = 1'b1;

  aat_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // A stage moves when it is empty or when the stage after it moves.
  always_comb begin
    ctl.adv[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      ctl.adv[i] = !vld_r[i] || ctl.adv[i+1];
    end
    vld_nxt = vld_r;
    if (ctl.adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NS; i++) begin
      if (ctl.adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    aat_axis u_axis (
      .clk    (clk),
      .ctl    (ctl),
      .row    (cfg.row[a]),
      .offset (cfg.offset[a]),
      .item   (in_data),
      .lo_o   (lo[a]),
      .hi_o   (hi[a]),
      .sat_o  (sat[a])
    );
  end

  assign in_stall  = !ctl.adv[0];
  assign out_valid = vld_r[NS-1];

  assign out_data.out_lo_x  = lo[0];
  assign out_data.out_lo_y  = lo[1];
  assign out_data.out_lo_z  = lo[2];
  assign out_data.out_hi_x  = hi[0];
  assign out_data.out_hi_y  = hi[1];
  assign out_data.out_hi_z  = hi[2];
  assign out_data.saturated = |sat;

  `AAT_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, vld_r[0],
    "accepted item did not enter the first stage")
  `AAT_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_valid, !in_stall,
    "input stalled while the output stage is empty")
  `AAT_ASSERT_NOW(a_lo_le_hi, clk, rst_n, out_valid,
    (out_data.out_lo_x <= out_data.out_hi_x) &&
    (out_data.out_lo_y <= out_data.out_hi_y) &&
    (out_data.out_lo_z <= out_data.out_hi_z),
    "result minimum exceeds maximum")

endmodule

`default_nettype wire

### sim/tb_aabb_affine_transform.sv
`timescale 1ns / 1ps
// Self-checking testbench for aabb_affine_transform: drives boxes and register writes,
// predicts the transformed bounds of each box and compares them with the block's results.
// Depends on aat_pkg and the block's RTL only.

module tb_aabb_affine_transform;
  import aat_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam longint COORD_HI = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [KW-1:0] K_MAX = {1'b0, {(KW - 1){1'b1}}};
  localparam logic [KW-1:0] K_MIN = {1'b1, {(KW - 1){1'b0}}};
  localparam logic [IDX_W-1:0] REG_SPARE_6 = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_SPARE_7 = IDX_W'(7);

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic [ROW_W-1:0] row_cfg [3];
  logic [CW-1:0] offset_cfg [3];

  in_item_t pending_boxes [$];
  out_item_t bounds_due [$];
  int boxes_queued = 0;
  int boxes_taken = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic long_hold = 1'b0;
  int hold_cnt = 0;

  aabb_affine_transform u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_coord(input longint x);
    if (x > COORD_HI) return COORD_HI;
    if (x < COORD_LO) return COORD_LO;
    return x;
  endfunction

  function automatic out_item_t box_bounds(input in_item_t b);
    longint lo [3];
    longint hi [3];
    longint p [3];
    longint mn [3];
    longint mx [3];
    longint acc;
    longint v;
    logic sat;
    out_item_t r;
    lo[0] = b.lo_x;
    lo[1] = b.lo_y;
    lo[2] = b.lo_z;
    hi[0] = b.hi_x;
    hi[1] = b.hi_y;
    hi[2] = b.hi_z;
    for (int c = 0; c < 8; c++) begin
      p[0] = c[2] ? hi[0] : lo[0];
      p[1] = c[1] ? hi[1] : lo[1];
      p[2] = c[0] ? hi[2] : lo[2];
      for (int a = 0; a < 3; a++) begin
        acc = longint'($signed(offset_cfg[a])) <<< FRAC;
        for (int k = 0; k < 3; k++) begin
          acc += longint'($signed(row_cfg[a][k*KW +: KW])) * p[k];
        end
        v = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        if (c == 0 || v < mn[a]) mn[a] = v;
        if (c == 0 || v > mx[a]) mx[a] = v;
      end
    end
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (sat_coord(mn[a]) != mn[a] || sat_coord(mx[a]) != mx[a]) sat = 1'b1;
    end
    r.out_lo_x = CW'(sat_coord(mn[0]));
    r.out_lo_y = CW'(sat_coord(mn[1]));
    r.out_lo_z = CW'(sat_coord(mn[2]));
    r.out_hi_x = CW'(sat_coord(mx[0]));
    r.out_hi_y = CW'(sat_coord(mx[1]));
    r.out_hi_z = CW'(sat_coord(mx[2]));
    r.saturated = sat;
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic cmp_field(input string name, input logic signed [CW-1:0] got,
                           input logic signed [CW-1:0] want);
    if (got !== want) note_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_bounds(input out_item_t got, input out_item_t want);
    cmp_field("out_lo_x", got.out_lo_x, want.out_lo_x);
    cmp_field("out_lo_y", got.out_lo_y, want.out_lo_y);
    cmp_field("out_lo_z", got.out_lo_z, want.out_lo_z);
    cmp_field("out_hi_x", got.out_hi_x, want.out_hi_x);
    cmp_field("out_hi_y", got.out_hi_y, want.out_hi_y);
    cmp_field("out_hi_z", got.out_hi_z, want.out_hi_z);
    cmp_field("saturated", CW'(got.saturated), CW'(want.saturated));
  endtask

  // Boxes enter at the falling edge; a new one is offered only after the last was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_boxes.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_data <= pending_boxes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!long_hold) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        bounds_due.push_back(box_bounds(in_data));
        boxes_taken++;
        in_taken = 1'b1;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (bounds_due.size() == 0) note_error("result arrived with no box outstanding");
        else check_bounds(out_data, bounds_due.pop_front());
      end
      if (cfg_psel && cfg_penable && cfg_pready) quiet_cycles = 0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, {IDX_LSB{1'b0}}};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_LIN_ROW_X: row_cfg[0] = val[ROW_W-1:0];
      REG_LIN_ROW_Y: row_cfg[1] = val[ROW_W-1:0];
      REG_LIN_ROW_Z: row_cfg[2] = val[ROW_W-1:0];
      REG_OFFSET_X: offset_cfg[0] = val[CW-1:0];
      REG_OFFSET_Y: offset_cfg[1] = val[CW-1:0];
      REG_OFFSET_Z: offset_cfg[2] = val[CW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [DATA_W-1:0] rx, ry, rz, ox, oy, oz);
    write_reg(REG_LIN_ROW_X, rx);
    write_reg(REG_LIN_ROW_Y, ry);
    write_reg(REG_LIN_ROW_Z, rz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
  endtask

  function automatic logic [CW-1:0] pick_coord();
    logic [CW-1:0] r;
    r = CW'($urandom);
    case ($urandom_range(6))
      0: r = C_MAX;
      1: r = C_MIN;
      2: r = '0;
      3: r = CW'($signed(r[12:0]));
      4: r = CW'($signed(r[19:0]));
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KW-1:0] pick_coef();
    logic [KW-1:0] r;
    r = KW'($urandom);
    case ($urandom_range(6))
      0: r = K_MAX;
      1: r = K_MIN;
      2: r = COEF_ONE;
      3: r = ~COEF_ONE + 1'b1;
      4: r = KW'($signed(r[14:0]));
      5: r = '0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_row();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    v[ROW_W-1:0] = {pick_coef(), pick_coef(), pick_coef()};
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_offset();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    v[CW-1:0] = pick_coord();
    return v;
  endfunction

  task automatic push_box(input logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    in_item_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    pending_boxes.push_back(b);
    boxes_queued++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_box(pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord());
  endtask

  // Corner cases: empty box, extremes, full range, inverted boxes, alternating bits.
  task automatic push_directed();
    push_box('0, '0, '0, '0, '0, '0);
    push_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    push_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    push_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    push_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
    push_box(CW'(1), CW'(2), CW'(3), -CW'(1), -CW'(2), -CW'(3));
    push_box(24'h555555, 24'h555555, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA);
    push_box(-CW'(1), -CW'(1), -CW'(1), CW'(1), CW'(1), CW'(1));
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 45; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 45; end
      default: begin gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  task automatic drain();
    do @(negedge clk); while (boxes_taken != boxes_queued || bounds_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    row_cfg[0] = ROW_W'(COEF_ONE);
    row_cfg[1] = ROW_W'(COEF_ONE) << KW;
    row_cfg[2] = ROW_W'(COEF_ONE) << (2 * KW);
    for (int a = 0; a < 3; a++) offset_cfg[a] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_mode(0);
    push_directed();
    drain();

    write_all({10'h3FF, {3{K_MAX}}}, {10'h3FF, {3{K_MAX}}}, {10'h3FF, {3{K_MAX}}},
              {40'hFFFFFFFFFF, C_MAX}, {40'hFFFFFFFFFF, C_MAX}, {40'hFFFFFFFFFF, C_MAX});
    push_directed();
    drain();

    write_all({10'h000, {3{K_MIN}}}, {10'h000, {3{K_MIN}}}, {10'h000, {3{K_MIN}}},
              {40'h0, C_MIN}, {40'h0, C_MIN}, {40'h0, C_MIN});
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    push_directed();
    drain();

    // Output held off for a long stretch while boxes keep coming, so the pipe backs up.
    write_all(rand_row(), rand_row(), rand_row(), rand_offset(), rand_offset(), rand_offset());
    long_hold = 1'b1;
    push_random(40);
    drain();
    long_hold = 1'b0;

    for (int p = 0; p < 8; p++) begin
      write_all(rand_row(), rand_row(), rand_row(),
                rand_offset(), rand_offset(), rand_offset());
      set_mode(p % 4);
      push_random(56);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
